### src/fsps_pkg.sv
package fsps_pkg;

	localparam int MAX_TERMS   = 1024;
	localparam int ADDR_W      = 10;
	localparam int COUNT_W     = 11;
	localparam int PHASE_BITS  = 16;
	localparam int COEF_BITS   = 32;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_ADDR_W = 10;
	localparam int SINE_W      = 16;
	localparam int PROD_W      = COEF_BITS + SINE_W;
	localparam int TERM_W      = PROD_W + 1 - 15;
	localparam int ACC_W       = 48;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// taylor divisors, odd series (sine) and even series (cosine)
	localparam longint unsigned DIV_ODD [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
	localparam longint unsigned DIV_EVEN[8] = '{2, 12, 30, 56, 90, 132, 182, 240};

	typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

	typedef struct packed {
		logic                     valid;
		logic signed [TERM_W-1:0] re;
		logic signed [TERM_W-1:0] im;
	} term_t;

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t       tab;
		longint unsigned r4;
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint          sum;
		longint          v;
		int              k;
		int              n;
		logic            odd;
		for (k = 0; k < SINE_DEPTH; k++) begin
			r4  = 64'(4 * k);
			q   = r4 / SINE_DEPTH;
			r   = r4 % SINE_DEPTH;
			x   = (r * HALF_PI_Q30 + SINE_DEPTH / 2) / SINE_DEPTH;
			odd = ((q & 64'd1) == 64'd0);
			x2  = (x * x) >> 30;
			t   = odd ? x : (64'd1 << 30);
			sum = longint'(t);
			for (n = 1; n <= 8; n++) begin
				if (odd) begin
					t = ((t * x2) >> 30) / DIV_ODD[n-1];
				end else begin
					t = ((t * x2) >> 30) / DIV_EVEN[n-1];
				end
				if ((n % 2) == 1) begin
					sum = sum - longint'(t);
				end else begin
					sum = sum + longint'(t);
				end
			end
			v = sum;
			if (v < 0) begin
				v = 0;
			end
			v = (v + 64'sd16384) >>> 15;
			if (v > 32767) begin
				v = 32767;
			end
			if (q >= 64'd2) begin
				v = -v;
			end
			tab[k] = SINE_W'(v);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### src/fourier_series_point_synth_top.sv
// load beat: written to coefficient memory at acceptance; ready stays high
// evaluate beat: result valid once n terms, n = min(term_count, 1024), have been issued
// and the pipeline has drained; a result still held by back-pressure stalls the sequencer
// throughput: one term per cycle, limited by the single coefficient memory read port
// reset: arst_n clears control, config (term_count 1, others 0) and the output valid flag
// coefficient memory is not cleared and needs no clearing pass
module fourier_series_point_synth_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// coef_index[9:0], coef_real[41:10], coef_imag[73:42], eval_angle[89:74], zero pad
	input  logic [95:0] s_axis_tdata,
	// mode[0]
	input  logic        s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sum_real[47:0], sum_imag[95:48]
	output logic [95:0] m_axis_tdata,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [1:0] CFG_TERM_COUNT = 2'd0;
	localparam logic [1:0] CFG_ROTATION   = 2'd1;
	localparam logic [1:0] CFG_OFFSET_RE  = 2'd2;
	localparam logic [1:0] CFG_OFFSET_IM  = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam int AW = fsps_pkg::ADDR_W;
	localparam int CW = fsps_pkg::COUNT_W;
	localparam int PB = fsps_pkg::PHASE_BITS;
	localparam int SA = fsps_pkg::SINE_ADDR_W;
	localparam int KW = fsps_pkg::COEF_BITS;

	// configuration registers
	logic [CW-1:0]        term_count_q;
	logic [PB-1:0]        rotation_q;
	logic signed [31:0]   offset_re_q;
	logic signed [31:0]   offset_im_q;

	// input beat fields
	logic                 in_mode;
	logic [AW-1:0]        in_index;
	logic signed [31:0]   in_real;
	logic signed [31:0]   in_imag;
	logic [15:0]          in_angle;
	logic                 in_beat;

	// sequencer
	logic [1:0]           state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        n_q;
	logic [PB-1:0]        angle_q;
	logic [PB-1:0]        ph_q;
	logic [PB-1:0]        ph_cos;
	logic                 issue;
	logic                 v_s1;
	logic [CW-1:0]        n_clip;
	logic                 pipe_busy;
	logic                 v_s2_mirror;
	logic                 out_load;

	// datapath
	logic signed [KW-1:0]                  coef_re;
	logic signed [KW-1:0]                  coef_im;
	logic signed [fsps_pkg::SINE_W-1:0]    sin_v;
	logic signed [fsps_pkg::SINE_W-1:0]    cos_v;
	fsps_pkg::term_t                       term;
	logic signed [fsps_pkg::ACC_W-1:0]     acc_q;

	// output register
	logic                 m_valid_q;
	logic [95:0]          m_data_q;

	assign in_mode  = s_axis_tuser;
	assign in_index = s_axis_tdata[9:0];
	assign in_real  = s_axis_tdata[41:10];
	assign in_imag  = s_axis_tdata[73:42];
	assign in_angle = s_axis_tdata[89:74];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// term count above the memory depth sums the whole memory
	assign n_clip = (term_count_q > CW'(fsps_pkg::MAX_TERMS)) ?
		CW'(fsps_pkg::MAX_TERMS) : term_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= CW'(1);
			rotation_q   <= '0;
			offset_re_q  <= '0;
			offset_im_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TERM_COUNT: term_count_q <= cfg_wdata[CW-1:0];
				CFG_ROTATION:   rotation_q   <= cfg_wdata[PB-1:0];
				CFG_OFFSET_RE:  offset_re_q  <= cfg_wdata;
				CFG_OFFSET_IM:  offset_im_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// issue one coefficient and table read per cycle while terms remain
	assign issue  = (state_q == ST_RUN) && (cnt_q < n_q);
	// cosine is the sine a quarter turn ahead
	assign ph_cos = ph_q + PB'(1 << (PB - 2));

	// finished sum moves into the output register once it is free
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat && (in_mode == MODE_EVAL)) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (!v_s1 && !term.valid && !pipe_busy) begin
						// all terms issued and the pipeline has drained
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the sum until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// products still in the multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_mirror <= 1'b0;
		end else begin
			v_s2_mirror <= v_s1;
		end
	end

	assign pipe_busy = v_s2_mirror;

	always_ff @(posedge clk) begin
		if (in_beat && (in_mode == MODE_EVAL)) begin
			n_q     <= n_clip;
			angle_q <= in_angle[PB-1:0];
			ph_q    <= rotation_q;
		end else if (issue) begin
			// phase of harmonic i is i*t + rotation, stepped by t
			ph_q <= ph_q + angle_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (in_mode == MODE_EVAL)) begin
			acc_q <= fsps_pkg::ACC_W'(offset_re_q);
		end else if (term.valid) begin
			acc_q <= acc_q + fsps_pkg::ACC_W'(term.re);
		end
	end

	// imaginary accumulator
	logic signed [fsps_pkg::ACC_W-1:0] acc_im_q;

	always_ff @(posedge clk) begin
		if (in_beat && (in_mode == MODE_EVAL)) begin
			acc_im_q <= fsps_pkg::ACC_W'(offset_im_q);
		end else if (term.valid) begin
			acc_im_q <= acc_im_q + fsps_pkg::ACC_W'(term.im);
		end
	end

	// sums stay well inside 48 bits, so the accumulators carry no saturation logic
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {acc_im_q, acc_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	fsps_coef_ram u_coef_ram (
		.clk      (clk),
		.we       (in_beat && (in_mode == MODE_LOAD)),
		.waddr    (in_index),
		.wdata_re (KW'(in_real)),
		.wdata_im (KW'(in_imag)),
		.raddr    (cnt_q[AW-1:0]),
		.rdata_re (coef_re),
		.rdata_im (coef_im)
	);

	fsps_sine_rom u_sine_rom (
		.clk      (clk),
		.addr_sin (ph_q[PB-1:PB-SA]),
		.addr_cos (ph_cos[PB-1:PB-SA]),
		.sin_q    (sin_v),
		.cos_q    (cos_v)
	);

	fsps_term_mac u_term_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (v_s1),
		.a      (coef_re),
		.b      (coef_im),
		.s      (sin_v),
		.c      (cos_v),
		.term   (term)
	);

endmodule

### src/fsps_coef_ram.sv
module fsps_coef_ram (
	input  logic                                clk,
	input  logic                                we,
	input  logic [fsps_pkg::ADDR_W-1:0]         waddr,
	input  logic signed [fsps_pkg::COEF_BITS-1:0] wdata_re,
	input  logic signed [fsps_pkg::COEF_BITS-1:0] wdata_im,
	input  logic [fsps_pkg::ADDR_W-1:0]         raddr,
	output logic signed [fsps_pkg::COEF_BITS-1:0] rdata_re,
	output logic signed [fsps_pkg::COEF_BITS-1:0] rdata_im
);

	// one word per slot: imaginary part high, real part low
	logic [2*fsps_pkg::COEF_BITS-1:0] mem [fsps_pkg::MAX_TERMS];
	logic [2*fsps_pkg::COEF_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wdata_im, wdata_re};
		end
		rd_q <= mem[raddr];
	end

	assign rdata_re = rd_q[fsps_pkg::COEF_BITS-1:0];
	assign rdata_im = rd_q[2*fsps_pkg::COEF_BITS-1:fsps_pkg::COEF_BITS];

endmodule

### src/fsps_sine_rom.sv
module fsps_sine_rom (
	input  logic                                  clk,
	input  logic [fsps_pkg::SINE_ADDR_W-1:0]      addr_sin,
	input  logic [fsps_pkg::SINE_ADDR_W-1:0]      addr_cos,
	output logic signed [fsps_pkg::SINE_W-1:0]    sin_q,
	output logic signed [fsps_pkg::SINE_W-1:0]    cos_q
);

	// two registered read ports on the constant full-period sine table
	always_ff @(posedge clk) begin
		sin_q <= fsps_pkg::SINE_TAB[addr_sin];
		cos_q <= fsps_pkg::SINE_TAB[addr_cos];
	end

endmodule

### src/fsps_term_mac.sv
module fsps_term_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  valid,
	input  logic signed [fsps_pkg::COEF_BITS-1:0] a,
	input  logic signed [fsps_pkg::COEF_BITS-1:0] b,
	input  logic signed [fsps_pkg::SINE_W-1:0]    s,
	input  logic signed [fsps_pkg::SINE_W-1:0]    c,
	output fsps_pkg::term_t                       term
);

	logic                                 v_s2;
	logic signed [fsps_pkg::PROD_W-1:0]   ac_s2;
	logic signed [fsps_pkg::PROD_W-1:0]   bs_s2;
	logic signed [fsps_pkg::PROD_W-1:0]   as_s2;
	logic signed [fsps_pkg::PROD_W-1:0]   bc_s2;
	logic signed [fsps_pkg::PROD_W:0]     diff_re;
	logic signed [fsps_pkg::PROD_W:0]     diff_im;
	logic signed [fsps_pkg::PROD_W:0]     rnd_re;
	logic signed [fsps_pkg::PROD_W:0]     rnd_im;
	logic                                 v_s3;
	logic signed [fsps_pkg::TERM_W-1:0]   re_s3;
	logic signed [fsps_pkg::TERM_W-1:0]   im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ac_s2 <= a * c;
		bs_s2 <= b * s;
		as_s2 <= a * s;
		bc_s2 <= b * c;
	end

	// q23 difference (real) and sum (imag), then round half up to q8
	assign diff_re = {ac_s2[fsps_pkg::PROD_W-1], ac_s2} - {bs_s2[fsps_pkg::PROD_W-1], bs_s2};
	assign diff_im = {as_s2[fsps_pkg::PROD_W-1], as_s2} + {bc_s2[fsps_pkg::PROD_W-1], bc_s2};
	assign rnd_re  = diff_re + (fsps_pkg::PROD_W+1)'(16384);
	assign rnd_im  = diff_im + (fsps_pkg::PROD_W+1)'(16384);

	always_ff @(posedge clk) begin
		re_s3 <= rnd_re[fsps_pkg::PROD_W:15];
		im_s3 <= rnd_im[fsps_pkg::PROD_W:15];
	end

	assign term.valid = v_s3;
	assign term.re    = re_s3;
	assign term.im    = im_s3;

endmodule
